// ----- rtl/syrk_pkg.sv -----
// syrk_pkg: shared types and constants for the symmetric rank-k update block
// field widths, item action codes, register indexes, controller states,
// command and status structs; no dependencies

package syrk_pkg;

  localparam int ROW_W   = 5;    // row and column index fields
  localparam int VAL_W   = 32;   // input element value
  localparam int A_W     = 16;   // stored A element
  localparam int RES_W   = 52;   // stored C entry and result value
  localparam int CFG_W   = 16;   // widest configuration register
  localparam int CFGI_W  = 2;    // configuration register index
  localparam int SIZE_W  = 6;    // n_used and k_used registers
  localparam int SPLIT_W = 26;   // C entry split for the beta products

  typedef enum logic [1:0] {
    ACT_WR_A    = 2'd0,
    ACT_WR_C    = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_RD_C    = 2'd3
  } action_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_ALPHA  = 2'd0,
    CFG_BETA   = 2'd1,
    CFG_N_USED = 2'd2,
    CFG_K_USED = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_OUT,
    S_C_RD,
    S_MAC,
    S_DRAIN,
    S_C_MUL,
    S_C_SUM,
    S_C_WR
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wr_a;       // store the item's value into A
    logic wr_c;       // store the item's value into C
    logic rd_cap;     // capture the read item's row and column
    logic c_rd_item;  // C read port addressed by the captured read item
    logic out_load;   // load the output register
    logic idx_clr;    // i and j back to zero
    logic j_next;     // next column of the lower triangle
    logic i_next;     // next row, column back to zero
    logic p_clr;      // inner index back to zero
    logic p_inc;      // issue one multiply-accumulate step
    logic acc_clr;    // clear the accumulator
    logic c_mul;      // beta partial products
    logic c_sum;      // combine the beta partial products
    logic c_wr;       // write the updated C entry
  } syrk_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic n_zero;
    logic k_zero;
    logic p_last;
    logic j_last;
    logic i_last;
    logic mac_busy;
    logic out_free;
  } syrk_stat_t;

endpackage

// ----- rtl/syrk_in_if.sv -----
// syrk_in_if: input item channel, valid/ready with action, row, col, value
// depends on syrk_pkg for the field widths

interface syrk_in_if import syrk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic [VAL_W-1:0] value;

  modport source (output valid, output action, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input action, input row, input col, input value,
                  output ready);
endinterface

// ----- rtl/syrk_out_if.sv -----
// syrk_out_if: result item channel, valid/ready with value, row, col
// depends on syrk_pkg for the field widths

interface syrk_out_if import syrk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result_value;
  logic [ROW_W-1:0] result_row;
  logic [ROW_W-1:0] result_col;

  modport source (output valid, output result_value, output result_row,
                  output result_col, input ready);
  modport sink   (input valid, input result_value, input result_row,
                  input result_col, output ready);
endinterface

// ----- rtl/syrk_ctrl.sv -----
// syrk_ctrl: sequencing state machine for loads, reads and the compute pass
// depends on syrk_pkg (state_t, action_t, syrk_cmd_t, syrk_stat_t)

module syrk_ctrl import syrk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  input  syrk_stat_t stat,
  output syrk_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (in_action)
            ACT_WR_A: cmd.wr_a = 1'b1;
            ACT_WR_C: cmd.wr_c = 1'b1;
            ACT_COMPUTE: begin
              cmd.idx_clr = 1'b1;
              if (!stat.n_zero) begin
                state_nxt = S_C_RD;
              end
            end
            ACT_RD_C: begin
              cmd.rd_cap = 1'b1;
              state_nxt  = S_RD_ADDR;
            end
            default: ;
          endcase
        end
      end
      S_RD_ADDR: begin
        cmd.c_rd_item = 1'b1;
        state_nxt     = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.c_rd_item = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_C_RD: begin
        // C entry read issued here, held while the address stays
        cmd.acc_clr = 1'b1;
        cmd.p_clr   = 1'b1;
        state_nxt   = stat.k_zero ? S_C_MUL : S_MAC;
      end
      S_MAC: begin
        cmd.p_inc = 1'b1;
        if (stat.p_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.mac_busy) begin
          state_nxt = S_C_MUL;
        end
      end
      S_C_MUL: begin
        cmd.c_mul = 1'b1;
        state_nxt = S_C_SUM;
      end
      S_C_SUM: begin
        cmd.c_sum = 1'b1;
        state_nxt = S_C_WR;
      end
      S_C_WR: begin
        cmd.c_wr = 1'b1;
        if (stat.j_last) begin
          if (stat.i_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.i_next = 1'b1;
            state_nxt  = S_C_RD;
          end
        end else begin
          cmd.j_next = 1'b1;
          state_nxt  = S_C_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/syrk_dp.sv -----
// syrk_dp: A and C memories, loop counters, multiply-accumulate pipeline,
// beta scaling, configuration registers and the output register
// depends on syrk_pkg (widths, register indexes, command and status structs)

module syrk_dp import syrk_pkg::*; #(
  parameter int MAX_N = 32,
  parameter int MAX_K = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [ROW_W-1:0]  in_col,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [RES_W-1:0]  out_result_value,
  output logic [ROW_W-1:0]  out_result_row,
  output logic [ROW_W-1:0]  out_result_col,
  input  syrk_cmd_t         cmd,
  output syrk_stat_t        stat
);

  localparam int NW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int NCW = $clog2(MAX_N + 1);
  localparam int KCW = $clog2(MAX_K + 1);
  localparam int PW  = 2 * A_W;          // A times A
  localparam int QW  = PW + CFG_W;       // alpha times that
  localparam int LW  = CFG_W + SPLIT_W + 1;
  localparam int HW  = CFG_W + (RES_W - SPLIT_W);

  // configuration
  logic signed [CFG_W-1:0]  alpha_r, beta_r;
  logic        [SIZE_W-1:0] n_used_r, k_used_r;
  logic        [NCW-1:0]    n_eff;
  logic        [KCW-1:0]    k_eff;

  // memories
  logic [A_W-1:0]   a_mem [MAX_N][MAX_K];
  logic [RES_W-1:0] c_mem [MAX_N][MAX_N];

  // counters
  logic [NW-1:0] i_r, j_r;
  logic [KW-1:0] p_r;

  // multiply-accumulate pipeline
  logic signed [A_W-1:0]   a_x_r, a_y_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [QW-1:0]    aprod_r;
  logic                    v1_r, v2_r, v3_r;
  logic        [RES_W-1:0] acc_r;

  // C read, beta scaling, write back
  logic        [RES_W-1:0] c_rdata_r;
  logic        [NW-1:0]    c_rrow, c_rcol, c_wrow, c_wcol;
  logic        [RES_W-1:0] c_wdata;
  logic                    c_we;
  logic signed [LW-1:0]    pp_lo_r;
  logic signed [HW-1:0]    pp_hi_r;
  logic        [RES_W-1:0] bc_r;

  // captured read item
  logic [ROW_W-1:0] rd_row_r, rd_col_r;
  logic             rd_ok_r;
  logic             in_a_ok, in_c_ok;

  // output register
  logic             out_valid_r;
  logic [RES_W-1:0] out_value_r;
  logic [ROW_W-1:0] out_row_r, out_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= CFG_W'(1);
      beta_r   <= CFG_W'(1);
      n_used_r <= SIZE_W'(32);
      k_used_r <= SIZE_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:  alpha_r  <= cfg_wdata;
        CFG_BETA:   beta_r   <= cfg_wdata;
        CFG_N_USED: n_used_r <= cfg_wdata[SIZE_W-1:0];
        CFG_K_USED: k_used_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes above the memory depth act as the depth
  assign n_eff = (32'(n_used_r) > MAX_N) ? NCW'(MAX_N) : NCW'(n_used_r);
  assign k_eff = (32'(k_used_r) > MAX_K) ? KCW'(MAX_K) : KCW'(k_used_r);

  assign in_a_ok = (32'(in_row) < MAX_N) && (32'(in_col) < MAX_K);
  assign in_c_ok = (32'(in_row) < MAX_N) && (32'(in_col) < MAX_N);

  // A memory: one write port, two read ports
  always_ff @(posedge clk) begin
    if (cmd.wr_a && in_a_ok) begin
      a_mem[NW'(in_row)][KW'(in_col)] <= in_value[A_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    a_x_r <= a_mem[i_r][p_r];
    a_y_r <= a_mem[j_r][p_r];
  end

  // C memory: one write port, one read port
  assign c_we    = (cmd.wr_c && in_c_ok) || cmd.c_wr;
  assign c_wrow  = cmd.c_wr ? i_r : NW'(in_row);
  assign c_wcol  = cmd.c_wr ? j_r : NW'(in_col);
  assign c_wdata = cmd.c_wr ? (acc_r + bc_r)
                            : {{(RES_W-VAL_W){in_value[VAL_W-1]}}, in_value};
  assign c_rrow  = cmd.c_rd_item ? NW'(rd_row_r) : i_r;
  assign c_rcol  = cmd.c_rd_item ? NW'(rd_col_r) : j_r;

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_wrow][c_wcol] <= c_wdata;
    end
  end

  always_ff @(posedge clk) begin
    c_rdata_r <= c_mem[c_rrow][c_rcol];
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.i_next) begin
      i_r <= i_r + NW'(1);
      j_r <= '0;
    end else if (cmd.j_next) begin
      j_r <= j_r + NW'(1);
    end
    if (cmd.p_clr) begin
      p_r <= '0;
    end else if (cmd.p_inc) begin
      p_r <= p_r + KW'(1);
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.p_inc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // alpha folded into every product, accumulated modulo the result width
  always_ff @(posedge clk) begin
    prod_r  <= a_x_r * a_y_r;
    aprod_r <= alpha_r * prod_r;
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + {{(RES_W-QW){aprod_r[QW-1]}}, aprod_r};
    end
  end

  // beta times C as a low unsigned half and a high signed half
  always_ff @(posedge clk) begin
    if (cmd.c_mul) begin
      pp_lo_r <= beta_r * $signed({1'b0, c_rdata_r[SPLIT_W-1:0]});
      pp_hi_r <= beta_r * $signed(c_rdata_r[RES_W-1:SPLIT_W]);
    end
    if (cmd.c_sum) begin
      bc_r <= {{(RES_W-LW){pp_lo_r[LW-1]}}, pp_lo_r}
            + {pp_hi_r[RES_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}};
    end
  end

  // read item capture and output register
  always_ff @(posedge clk) begin
    if (cmd.rd_cap) begin
      rd_row_r <= in_row;
      rd_col_r <= in_col;
      rd_ok_r  <= in_c_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= rd_ok_r ? c_rdata_r : '0;
      out_row_r   <= rd_row_r;
      out_col_r   <= rd_col_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_row   = out_row_r;
  assign out_result_col   = out_col_r;

  assign stat.n_zero   = (n_eff == '0);
  assign stat.k_zero   = (k_eff == '0);
  assign stat.p_last   = ((KCW'(p_r) + KCW'(1)) == k_eff);
  assign stat.j_last   = (j_r == i_r);
  assign stat.i_last   = ((NCW'(i_r) + NCW'(1)) == n_eff);
  assign stat.mac_busy = v1_r || v2_r || v3_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// ----- rtl/symmetric_rank_k_update_lower.sv -----
// symmetric_rank_k_update_lower: top level, integer rank-k update of the
// lower triangle of C; joins syrk_ctrl and syrk_dp
// depends on syrk_pkg, syrk_in_if and syrk_out_if
//
//  channel  direction  carries                          handshake
//  in_if    sink       action, row, col, value          valid/ready
//  out_if   source     result_value, result_row/col     valid/ready
//  cfg_*    input      cfg_index, cfg_wdata             cfg_we, no wait
//
// load items (A or C element) are written in the cycle they are accepted; a
// read item captures its row and column, reads C and loads the output
// register before the next item is accepted, waiting while out_if is stalled
// a compute item visits the n(n+1)/2 lower-triangle entries: per C entry it
// fetches the C entry, runs the k-step multiply-accumulate loop over the two
// A read ports, drains the multiply pipeline, scales by beta and writes back
// the result sits in an output register, so loads and computes go on while a
// read result waits; synchronous reset covers control and configuration state

module symmetric_rank_k_update_lower import syrk_pkg::*; #(
  parameter int MAX_N = 32,
  parameter int MAX_K = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  syrk_in_if.sink           in_if,
  syrk_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  syrk_cmd_t  cmd;
  syrk_stat_t stat;

  // sequencing of item types and the triangle / inner loops
  syrk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_action (in_if.action),
    .in_ready  (in_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memories, arithmetic, configuration and output register
  syrk_dp #(
    .MAX_N (MAX_N),
    .MAX_K (MAX_K)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_row           (in_if.row),
    .in_col           (in_if.col),
    .in_value         (in_if.value),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_result_value (out_if.result_value),
    .out_result_row   (out_if.result_row),
    .out_result_col   (out_if.result_col),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule
